### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/aes_pkg.sv
`default_nettype none

package aes_pkg;

    localparam int NUM_ROUNDS = 10;

    // byte n of a block at element n; element 0 in the top bits
    typedef logic [0:15][7:0] t_block;

    typedef struct packed {
        logic   valid;
        t_block state;
        t_block key;
    } t_lane;

    localparam logic [7:0] RCON [1:NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[4*r + c] = SBOX[s[4*r + ((c + r) % 4)]];
            end
        end
        return t;
    endfunction

    function automatic t_block mix_cols(input t_block s);
        t_block     t;
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[c];
            a1 = s[4 + c];
            a2 = s[8 + c];
            a3 = s[12 + c];
            d0 = xtime(a0);
            d1 = xtime(a1);
            d2 = xtime(a2);
            d3 = xtime(a3);
            t[c]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
            t[4 + c]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
            t[8 + c]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
            t[12 + c] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
        end
        return t;
    endfunction

    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        t_block     n;
        logic [7:0] t [4];
        for (int r = 0; r < 4; r++) begin
            t[r] = SBOX[k[4*((r + 1) % 4) + 3]];
        end
        t[0] = t[0] ^ rc;
        for (int r = 0; r < 4; r++) begin
            n[4*r] = k[4*r] ^ t[r];
            for (int c = 1; c < 4; c++) begin
                n[4*r + c] = k[4*r + c] ^ n[4*r + c - 1];
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/aes128_block_encrypt.sv
// A block taken at a clock edge is registered in one key-add stage and then in one cell
// per round before it leaves on o_valid.
// Throughput: one block per cycle; busy stays low and the receiver cannot stall.
// Reset (synchronous, active low) clears every stage's valid bit and both keys.
`default_nettype none

module aes128_block_encrypt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_plain_high,
    input  logic [63:0] i_plain_low,
    output logic        o_valid,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import aes_pkg::*;

`include "assert_macros.svh"

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic        cfg_wr;
    logic        r_valid0;
    t_block      r_state0;
    t_block      r_key0;
    t_lane       lanes [0:NUM_ROUNDS];

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[3] ? r_key_low : r_key_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_key_low <= pwdata;
            end else begin
                r_key_high <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else begin
            r_valid0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state0 <= {i_plain_high, i_plain_low} ^ {r_key_high, r_key_low};
        r_key0   <= {r_key_high, r_key_low};
    end

    assign lanes[0] = '{valid: r_valid0, state: r_state0, key: r_key0};

    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
        aes_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_lane   (lanes[g-1]),
            .i_rcon   (RCON[g]),
            .i_mix_en (g != NUM_ROUNDS),
            .o_lane   (lanes[g])
        );
    end

    assign o_valid       = lanes[NUM_ROUNDS].valid;
    assign o_cipher_high = lanes[NUM_ROUNDS].state[0:7];
    assign o_cipher_low  = lanes[NUM_ROUNDS].state[8:15];

    `ASSERT_IMPL(a_result_latency, o_valid, $past(start && !busy, NUM_ROUNDS + 1))
    `ASSERT_NEXT(a_key_hold, !cfg_wr, $stable(r_key_high) && $stable(r_key_low))

endmodule

`default_nettype wire

### rtl/aes_cell.sv
`default_nettype none

module aes_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aes_pkg::t_lane i_lane,
    input  logic [7:0]    i_rcon,
    input  logic          i_mix_en,
    output aes_pkg::t_lane o_lane
);
    import aes_pkg::*;

    logic   r_valid;
    t_block r_state, n_state;
    t_block r_key, n_key;
    t_block sub_out;

    always_comb begin
        n_key   = next_key(i_lane.key, i_rcon);
        sub_out = sub_shift(i_lane.state);
        n_state = (i_mix_en ? mix_cols(sub_out) : sub_out) ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_key   <= n_key;
    end

    assign o_lane = '{valid: r_valid, state: r_state, key: r_key};

endmodule

`default_nettype wire
